[hdl/sfs_pkg.sv]
// ----------------------------------------------------------------------------
// sfs_pkg: shared types and constants of the sensor fault supervisor
// Holds the configuration layout, supervisor state, result codes and
// register reset values used by the datapath and register file.
// ----------------------------------------------------------------------------
package sfs_pkg;

  // Width of the wrapping millisecond time base
  localparam int unsigned TimeWidth = 32;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgDataWidth = 32;

  // Register indexes of the configuration port
  localparam logic [CfgIdxWidth-1:0] CFG_FAULT_DELAY   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_SOIL_RAW_LOW  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_SOIL_RAW_HIGH = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_WET_SET       = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CFG_WET_CLEAR     = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CFG_TEMP_FLOOR    = 3'd5;

  // Register reset values
  localparam logic [TimeWidth-1:0] FaultDelayRst    = TimeWidth'(30000);
  localparam logic [9:0]           SoilRawLowRst    = 10'd5;
  localparam logic [9:0]           SoilRawHighRst   = 10'd1020;
  localparam logic [6:0]           WetSetRst        = 7'd85;
  localparam logic [6:0]           WetClearRst      = 7'd80;
  localparam logic signed [11:0]   TempFloorRst     = -12'sd1000;

  // Fault codes
  typedef enum logic [1:0] {
    CODE_NONE = 2'd0,
    CODE_AIR  = 2'd1,
    CODE_SOIL = 2'd2,
    CODE_WET  = 2'd3
  } code_e;

  // Relay and fan commands
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_FORCE = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [TimeWidth-1:0] fault_delay_ms;
    logic [9:0]           soil_raw_low;
    logic [9:0]           soil_raw_high;
    logic [6:0]           overwater_set_pct;
    logic [6:0]           overwater_clear_pct;
    logic signed [11:0]   temp_floor_tenths;
  } cfg_t;

  typedef struct packed {
    logic                 tracking;
    logic [TimeWidth-1:0] now_ms;
    logic                 temp_valid;
    logic                 humi_valid;
    logic signed [11:0]   temp_tenths;
    logic [9:0]           soil_raw;
    logic [6:0]           soil_percent;
  } sample_t;

  typedef struct packed {
    logic                 safe_flag;
    code_e                error_state;
    logic                 air_pending;
    logic [TimeWidth-1:0] air_fault_start;
    logic                 soil_pending;
    logic [TimeWidth-1:0] soil_fault_start;
  } state_t;

  typedef struct packed {
    logic  safe_active;
    code_e fault_code;
    cmd_e  pump_lock_cmd;
    cmd_e  mist_lock_cmd;
    logic  fan_lock_clear;
    cmd_e  fan_cycle_cmd;
  } result_t;

endpackage

[hdl/sfs_cfg_regs.sv]
// ----------------------------------------------------------------------------
// sfs_cfg_regs: configuration register file
// Decodes register writes by index; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module sfs_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sfs_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [sfs_pkg::CfgDataWidth-1:0]   cfg_data_i,
  output sfs_pkg::cfg_t                      cfg_o
);
  import sfs_pkg::*;

  cfg_t cfg_q;

  // Always take a write beat
  assign cfg_ready_o = 1'b1;

  // Update the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fault_delay_ms      <= FaultDelayRst;
      cfg_q.soil_raw_low        <= SoilRawLowRst;
      cfg_q.soil_raw_high       <= SoilRawHighRst;
      cfg_q.overwater_set_pct   <= WetSetRst;
      cfg_q.overwater_clear_pct <= WetClearRst;
      cfg_q.temp_floor_tenths   <= TempFloorRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FAULT_DELAY:   cfg_q.fault_delay_ms      <= cfg_data_i[TimeWidth-1:0];
        CFG_SOIL_RAW_LOW:  cfg_q.soil_raw_low        <= cfg_data_i[9:0];
        CFG_SOIL_RAW_HIGH: cfg_q.soil_raw_high       <= cfg_data_i[9:0];
        CFG_WET_SET:       cfg_q.overwater_set_pct   <= cfg_data_i[6:0];
        CFG_WET_CLEAR:     cfg_q.overwater_clear_pct <= cfg_data_i[6:0];
        CFG_TEMP_FLOOR:    cfg_q.temp_floor_tenths   <= $signed(cfg_data_i[11:0]);
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/sfs_eval.sv]
// ----------------------------------------------------------------------------
// sfs_eval: per-sample fault qualification and safe-mode decision
// Computes the next supervisor state and the commands for one sample.
// ----------------------------------------------------------------------------
module sfs_eval (
  input  sfs_pkg::cfg_t    cfg_i,
  input  sfs_pkg::sample_t sample_i,
  input  sfs_pkg::state_t  state_i,
  output sfs_pkg::state_t  state_o,
  output sfs_pkg::result_t result_o
);
  import sfs_pkg::*;

  logic                 air_ok;
  logic                 soil_ok;
  logic [TimeWidth-1:0] air_elapsed;
  logic [TimeWidth-1:0] soil_elapsed;
  logic                 air_due;
  logic                 soil_due;

  // Classify the sensors and measure wrapping fault age
  assign air_ok  = sample_i.temp_valid && sample_i.humi_valid &&
                   (sample_i.temp_tenths > cfg_i.temp_floor_tenths);
  assign soil_ok = !((sample_i.soil_raw <= cfg_i.soil_raw_low) ||
                     (sample_i.soil_raw >= cfg_i.soil_raw_high));
  assign air_elapsed  = sample_i.now_ms - state_i.air_fault_start;
  assign soil_elapsed = sample_i.now_ms - state_i.soil_fault_start;
  assign air_due  = air_elapsed >= cfg_i.fault_delay_ms;
  assign soil_due = soil_elapsed >= cfg_i.fault_delay_ms;

  // When tracking, run air, soil, overwater, recovery in order; last action wins
  always_comb begin
    state_t  st;
    result_t res;
    st  = state_i;
    res = '{safe_active: 1'b0, fault_code: CODE_NONE, pump_lock_cmd: CMD_NONE,
            mist_lock_cmd: CMD_NONE, fan_lock_clear: 1'b0, fan_cycle_cmd: CMD_NONE};

    if (!sample_i.tracking) begin
      if (st.safe_flag) begin
        st.safe_flag       = 1'b0;
        st.error_state     = CODE_NONE;
        res.pump_lock_cmd  = CMD_CLEAR;
        res.mist_lock_cmd  = CMD_CLEAR;
        res.fan_lock_clear = 1'b1;
        res.fan_cycle_cmd  = CMD_CLEAR;
      end
    end else begin
      // Air sensor qualification
      if (!air_ok) begin
        if (!st.air_pending) begin
          st.air_pending     = 1'b1;
          st.air_fault_start = sample_i.now_ms;
        end else if (air_due && (st.error_state != CODE_AIR)) begin
          st.safe_flag      = 1'b1;
          st.error_state    = CODE_AIR;
          res.mist_lock_cmd = CMD_FORCE;
          res.fan_cycle_cmd = CMD_FORCE;
        end
      end else begin
        st.air_pending = 1'b0;
      end

      // Soil sensor qualification
      if (!soil_ok) begin
        if (!st.soil_pending) begin
          st.soil_pending     = 1'b1;
          st.soil_fault_start = sample_i.now_ms;
        end else if (soil_due && (st.error_state != CODE_SOIL)) begin
          st.safe_flag      = 1'b1;
          st.error_state    = CODE_SOIL;
          res.pump_lock_cmd = CMD_FORCE;
        end
      end else begin
        st.soil_pending = 1'b0;
      end

      // Overwater entry
      if (soil_ok && (sample_i.soil_percent > cfg_i.overwater_set_pct) &&
          (st.error_state != CODE_WET)) begin
        st.safe_flag      = 1'b1;
        st.error_state    = CODE_WET;
        res.pump_lock_cmd = CMD_FORCE;
      end

      // Recovery
      if (st.safe_flag) begin
        if (air_ok && soil_ok && (st.error_state != CODE_WET)) begin
          st.safe_flag       = 1'b0;
          st.error_state     = CODE_NONE;
          res.pump_lock_cmd  = CMD_CLEAR;
          res.mist_lock_cmd  = CMD_CLEAR;
          res.fan_lock_clear = 1'b1;
          res.fan_cycle_cmd  = CMD_CLEAR;
        end else if ((st.error_state == CODE_WET) && soil_ok &&
                     (sample_i.soil_percent <= cfg_i.overwater_clear_pct)) begin
          st.safe_flag      = 1'b0;
          st.error_state    = CODE_NONE;
          res.pump_lock_cmd = CMD_CLEAR;
        end
      end
    end

    res.safe_active = st.safe_flag;
    res.fault_code  = st.error_state;
    state_o  = st;
    result_o = res;
  end

endmodule

[hdl/sensor_fault_supervisor_unit.sv]
// ----------------------------------------------------------------------------
// sensor_fault_supervisor_unit: sensor fault qualification and safe mode
// Usage:
//  - Sample channel: in_valid_i with the sample fields; a beat is taken on a
//    rising edge with in_valid_i high and in_stall_o low.
//  - Result channel: out_valid_o with the command fields; a beat leaves on a
//    rising edge with out_valid_o high and out_stall_i low.
//  - Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//    cfg_ready_o is always high. Write only while no sample is in flight.
//  - Throughput: one sample per cycle while the result is not stalled, set by
//    the single evaluation stage between the sample register and the result register.
//  - Stall: while out_stall_i holds a result, the sample register can still
//    load one beat; in_stall_o rises once that register is full too.
//  - Reset: both registers empty, safe mode off, no pending faults, and all
//    thresholds at their default values.
// ----------------------------------------------------------------------------
module sensor_fault_supervisor_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Sample channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             tracking_i,
  input  logic [31:0]                      now_ms_i,
  input  logic                             temp_valid_i,
  input  logic                             humi_valid_i,
  input  logic signed [11:0]               temp_tenths_i,
  input  logic [9:0]                       soil_raw_i,
  input  logic [6:0]                       soil_percent_i,
  // Result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             safe_active_o,
  output logic [1:0]                       fault_code_o,
  output logic [1:0]                       pump_lock_cmd_o,
  output logic [1:0]                       mist_lock_cmd_o,
  output logic                             fan_lock_clear_o,
  output logic [1:0]                       fan_cycle_cmd_o,
  // Configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sfs_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [sfs_pkg::CfgDataWidth-1:0] cfg_data_i
);
  import sfs_pkg::*;

  cfg_t    cfg;
  sample_t smp_q;
  logic    smp_vld_q;
  state_t  state_q;
  state_t  state_d;
  result_t res_d;
  result_t res_q;
  logic    res_vld_q;
  logic    advance;
  logic    fire;

  sfs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sfs_eval u_eval (
    .cfg_i    (cfg),
    .sample_i (smp_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Handshake: result slot free or draining lets the pipe move
  assign advance    = !res_vld_q || !out_stall_i;
  assign fire       = smp_vld_q && advance;
  assign in_stall_o = smp_vld_q && !advance;

  // Sample register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      smp_vld_q <= in_valid_i;
    end
  end

  // Sample register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      smp_q.tracking     <= tracking_i;
      smp_q.now_ms       <= TimeWidth'(now_ms_i);
      smp_q.temp_valid   <= temp_valid_i;
      smp_q.humi_valid   <= humi_valid_i;
      smp_q.temp_tenths  <= temp_tenths_i;
      smp_q.soil_raw     <= soil_raw_i;
      smp_q.soil_percent <= soil_percent_i;
    end
  end

  // Supervisor state, updated as each sample is evaluated
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.safe_flag        <= 1'b0;
      state_q.error_state      <= CODE_NONE;
      state_q.air_pending      <= 1'b0;
      state_q.air_fault_start  <= '0;
      state_q.soil_pending     <= 1'b0;
      state_q.soil_fault_start <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= smp_vld_q;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = res_vld_q;
  assign safe_active_o    = res_q.safe_active;
  assign fault_code_o     = res_q.fault_code;
  assign pump_lock_cmd_o  = res_q.pump_lock_cmd;
  assign mist_lock_cmd_o  = res_q.mist_lock_cmd;
  assign fan_lock_clear_o = res_q.fan_lock_clear;
  assign fan_cycle_cmd_o  = res_q.fan_cycle_cmd;

endmodule

[dv/sensor_fault_supervisor_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_fault_supervisor_unit_tb: self-checking bench of the fault supervisor
// Walks a short table of directed samples, then random sample bursts under
// several threshold settings. A cycle-free safe-mode predictor, or a pinned
// row's result, checks each beat field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module sensor_fault_supervisor_unit_tb;
  import sfs_pkg::*;

  localparam int NumDirRows    = 24;
  localparam int PhaseItems    = 205;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 8;

  // Indexes past the last register; writes there must change nothing
  localparam logic [CfgIdxWidth-1:0] IdxSpareA = CFG_TEMP_FLOOR + 3'd1;
  localparam logic [CfgIdxWidth-1:0] IdxSpareB = CFG_TEMP_FLOOR + 3'd2;

  // Results that can be read off at a glance for the directed rows
  localparam result_t ResIdle     = '{1'b0, CODE_NONE, CMD_NONE, CMD_NONE, 1'b0, CMD_NONE};
  localparam result_t ResAirTrip  = '{1'b1, CODE_AIR, CMD_NONE, CMD_FORCE, 1'b0, CMD_FORCE};
  localparam result_t ResAirHold  = '{1'b1, CODE_AIR, CMD_NONE, CMD_NONE, 1'b0, CMD_NONE};
  localparam result_t ResRelease  = '{1'b0, CODE_NONE, CMD_CLEAR, CMD_CLEAR, 1'b1, CMD_CLEAR};
  localparam result_t ResSoilTrip = '{1'b1, CODE_SOIL, CMD_FORCE, CMD_NONE, 1'b0, CMD_NONE};
  localparam result_t ResSoilHold = '{1'b1, CODE_SOIL, CMD_NONE, CMD_NONE, 1'b0, CMD_NONE};
  localparam result_t ResWetTrip  = '{1'b1, CODE_WET, CMD_FORCE, CMD_NONE, 1'b0, CMD_NONE};
  localparam result_t ResWetHold  = '{1'b1, CODE_WET, CMD_NONE, CMD_NONE, 1'b0, CMD_NONE};
  localparam result_t ResWetClear = '{1'b0, CODE_NONE, CMD_CLEAR, CMD_NONE, 1'b0, CMD_NONE};

  typedef struct packed {
    sample_t smp;
    logic    pinned;
    result_t res;
  } dir_row_t;

  // Directed rows under reset thresholds: delay 30000, raw 5..1020, wet 85/80,
  // floor -1000. Fields: tracking, now, temp ok, humi ok, temp, raw, percent.
  localparam dir_row_t DirRows [NumDirRows] = '{
    '{'{1'b0, 32'd0,          1'b1, 1'b1, 12'sd250,   10'd500,  7'd50},  1'b1, ResIdle},
    '{'{1'b1, 32'd100,        1'b1, 1'b1, 12'sd250,   10'd500,  7'd50},  1'b1, ResIdle},
    '{'{1'b1, 32'd200,        1'b0, 1'b1, 12'sd250,   10'd500,  7'd50},  1'b1, ResIdle},
    '{'{1'b1, 32'd30199,      1'b0, 1'b1, 12'sd250,   10'd500,  7'd50},  1'b1, ResIdle},
    '{'{1'b1, 32'd30200,      1'b0, 1'b1, 12'sd250,   10'd500,  7'd50},  1'b1, ResAirTrip},
    '{'{1'b1, 32'd30300,      1'b1, 1'b0, 12'sd250,   10'd500,  7'd50},  1'b1, ResAirHold},
    '{'{1'b1, 32'd30400,      1'b1, 1'b1, 12'sd250,   10'd500,  7'd50},  1'b1, ResRelease},
    '{'{1'b1, 32'd40000,      1'b1, 1'b1, -12'sd1000, 10'd500,  7'd50},  1'b1, ResIdle},
    '{'{1'b1, 32'd70000,      1'b1, 1'b1, -12'sd2000, 10'd500,  7'd50},  1'b1, ResAirTrip},
    '{'{1'b0, 32'd70001,      1'b1, 1'b1, -12'sd2000, 10'd500,  7'd50},  1'b1, ResRelease},
    '{'{1'b1, 32'd80000,      1'b1, 1'b1, 12'sd2000,  10'd5,    7'd100}, 1'b1, ResIdle},
    '{'{1'b1, 32'd110000,     1'b1, 1'b1, 12'sd2000,  10'd0,    7'd100}, 1'b1, ResSoilTrip},
    '{'{1'b1, 32'd110001,     1'b1, 1'b1, 12'sd2000,  10'd1020, 7'd100}, 1'b1, ResSoilHold},
    '{'{1'b1, 32'd110002,     1'b0, 1'b1, 12'sd2000,  10'd1023, 7'd100}, 1'b1, ResSoilHold},
    '{'{1'b1, 32'd140002,     1'b0, 1'b1, 12'sd2000,  10'd1023, 7'd100}, 1'b0, ResIdle},
    '{'{1'b1, 32'd140003,     1'b0, 1'b0, 12'sd2000,  10'd1023, 7'd100}, 1'b0, ResIdle},
    '{'{1'b1, 32'd140010,     1'b1, 1'b1, 12'sd0,     10'd512,  7'd86},  1'b1, ResWetTrip},
    '{'{1'b1, 32'd140020,     1'b1, 1'b1, 12'sd0,     10'd512,  7'd81},  1'b1, ResWetHold},
    '{'{1'b1, 32'd140030,     1'b1, 1'b1, 12'sd0,     10'd512,  7'd80},  1'b1, ResWetClear},
    '{'{1'b1, 32'd140040,     1'b1, 1'b1, 12'sd0,     10'd1020, 7'd100}, 1'b1, ResIdle},
    '{'{1'b1, 32'hFFFF_FF00,  1'b0, 1'b1, 12'sd0,     10'd512,  7'd0},   1'b1, ResIdle},
    '{'{1'b1, 32'h0000_7430,  1'b0, 1'b1, 12'sd0,     10'd512,  7'd0},   1'b1, ResAirTrip},
    '{'{1'b0, 32'h0000_7431,  1'b0, 1'b1, 12'sd0,     10'd512,  7'd0},   1'b1, ResRelease},
    '{'{1'b0, 32'hFFFF_FFFF,  1'b1, 1'b1, -12'sd2000, 10'd1023, 7'd100}, 1'b1, ResIdle}
  };

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    tracking_i;
  logic [31:0]             now_ms_i;
  logic                    temp_valid_i;
  logic                    humi_valid_i;
  logic signed [11:0]      temp_tenths_i;
  logic [9:0]              soil_raw_i;
  logic [6:0]              soil_percent_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic                    safe_active_o;
  logic [1:0]              fault_code_o;
  logic [1:0]              pump_lock_cmd_o;
  logic [1:0]              mist_lock_cmd_o;
  logic                    fan_lock_clear_o;
  logic [1:0]              fan_cycle_cmd_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CfgIdxWidth-1:0]  cfg_index_i;
  logic [CfgDataWidth-1:0] cfg_data_i;

  sensor_fault_supervisor_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .tracking_i       (tracking_i),
    .now_ms_i         (now_ms_i),
    .temp_valid_i     (temp_valid_i),
    .humi_valid_i     (humi_valid_i),
    .temp_tenths_i    (temp_tenths_i),
    .soil_raw_i       (soil_raw_i),
    .soil_percent_i   (soil_percent_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .safe_active_o    (safe_active_o),
    .fault_code_o     (fault_code_o),
    .pump_lock_cmd_o  (pump_lock_cmd_o),
    .mist_lock_cmd_o  (mist_lock_cmd_o),
    .fan_lock_clear_o (fan_lock_clear_o),
    .fan_cycle_cmd_o  (fan_cycle_cmd_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // Supervisor copy: thresholds and safe-mode state
  cfg_t                 sup_cfg;
  logic                 sup_safe;
  code_e                sup_code;
  logic                 air_wait;
  logic [TimeWidth-1:0] air_since;
  logic                 soil_wait;
  logic [TimeWidth-1:0] soil_since;

  result_t supervisor_out_q [$];
  int      fail_count;
  int      quiet_cycles;

  // Typed-in result travelling with the current sample beat
  logic    pin_known;
  result_t pin_res;

  // Random sample source state
  logic [31:0] cur_ms;
  logic        air_bad;
  logic        soil_bad;
  int          wet_mode;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;
  wire cfg_fire = cfg_valid_i && cfg_ready_o;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Evaluate one sample and advance the supervisor state
  function automatic result_t supervise(input sample_t s);
    result_t              r;
    logic                 air_ok;
    logic                 soil_ok;
    logic [TimeWidth-1:0] air_age;
    logic [TimeWidth-1:0] soil_age;
    r = ResIdle;
    air_age = s.now_ms - air_since;
    soil_age = s.now_ms - soil_since;
    if (!s.tracking) begin
      // leave safe mode, keep pending faults as they are
      if (sup_safe) begin
        sup_safe = 1'b0;
        sup_code = CODE_NONE;
        r.pump_lock_cmd = CMD_CLEAR;
        r.mist_lock_cmd = CMD_CLEAR;
        r.fan_lock_clear = 1'b1;
        r.fan_cycle_cmd = CMD_CLEAR;
      end
    end else begin
      air_ok = s.temp_valid && s.humi_valid &&
               ($signed(s.temp_tenths) > $signed(sup_cfg.temp_floor_tenths));
      soil_ok = (s.soil_raw > sup_cfg.soil_raw_low) && (s.soil_raw < sup_cfg.soil_raw_high);

      // qualify the air fault
      if (!air_ok) begin
        if (!air_wait) begin
          air_wait = 1'b1;
          air_since = s.now_ms;
        end else if (air_age >= sup_cfg.fault_delay_ms && sup_code != CODE_AIR) begin
          sup_safe = 1'b1;
          sup_code = CODE_AIR;
          r.mist_lock_cmd = CMD_FORCE;
          r.fan_cycle_cmd = CMD_FORCE;
        end
      end else begin
        air_wait = 1'b0;
      end

      // qualify the soil fault
      if (!soil_ok) begin
        if (!soil_wait) begin
          soil_wait = 1'b1;
          soil_since = s.now_ms;
        end else if (soil_age >= sup_cfg.fault_delay_ms && sup_code != CODE_SOIL) begin
          sup_safe = 1'b1;
          sup_code = CODE_SOIL;
          r.pump_lock_cmd = CMD_FORCE;
        end
      end else begin
        soil_wait = 1'b0;
      end

      // overwater enters at once
      if (soil_ok && s.soil_percent > sup_cfg.overwater_set_pct && sup_code != CODE_WET) begin
        sup_safe = 1'b1;
        sup_code = CODE_WET;
        r.pump_lock_cmd = CMD_FORCE;
      end

      // recover
      if (sup_safe) begin
        if (air_ok && soil_ok && sup_code != CODE_WET) begin
          sup_safe = 1'b0;
          sup_code = CODE_NONE;
          r.pump_lock_cmd = CMD_CLEAR;
          r.mist_lock_cmd = CMD_CLEAR;
          r.fan_lock_clear = 1'b1;
          r.fan_cycle_cmd = CMD_CLEAR;
        end else if (sup_code == CODE_WET && soil_ok &&
                     s.soil_percent <= sup_cfg.overwater_clear_pct) begin
          sup_safe = 1'b0;
          sup_code = CODE_NONE;
          r.pump_lock_cmd = CMD_CLEAR;
        end
      end
    end
    r.safe_active = sup_safe;
    r.fault_code = sup_code;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [1:0] want,
                                      input logic [1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Build the next sample: mostly persistent faults on a running clock,
  // with some fully random noise beats
  function automatic sample_t next_sample();
    sample_t s;
    int      fl;
    int      lo;
    int      hi;
    int      wet_set;
    int      wet_clr;
    int      val;
    case ($urandom_range(0, 19))
      0:       cur_ms = $urandom();
      1:       cur_ms += $urandom_range(0, 100000);
      default: cur_ms += $urandom_range(0, 40);
    endcase
    if ($urandom_range(0, 14) == 0) air_bad = !air_bad;
    if ($urandom_range(0, 14) == 0) soil_bad = !soil_bad;
    if ($urandom_range(0, 9) == 0) wet_mode = $urandom_range(0, 2);

    fl = int'(sup_cfg.temp_floor_tenths);
    lo = int'(sup_cfg.soil_raw_low);
    hi = int'(sup_cfg.soil_raw_high);
    wet_set = int'(sup_cfg.overwater_set_pct);
    wet_clr = int'(sup_cfg.overwater_clear_pct);

    s.tracking = ($urandom_range(0, 24) != 0);
    s.now_ms = cur_ms;
    s.temp_valid = 1'b1;
    s.humi_valid = 1'b1;
    val = int'($urandom_range(0, 4000)) - 2000;

    // air sensor
    if (air_bad) begin
      case ($urandom_range(0, 2))
        0: s.temp_valid = 1'b0;
        1: s.humi_valid = 1'b0;
        default: begin
          if (fl >= -2000) val = int'($urandom_range(0, fl + 2000)) - 2000;
          else s.temp_valid = 1'b0;
        end
      endcase
    end else if (fl < 2000) begin
      val = fl + 1 + int'($urandom_range(0, 2000 - fl - 1));
    end else begin
      s.temp_valid = 1'b0;
    end
    s.temp_tenths = 12'(val);

    // soil sensor
    if (soil_bad) begin
      if ($urandom_range(0, 1) == 0) s.soil_raw = 10'($urandom_range(0, lo));
      else s.soil_raw = 10'($urandom_range(hi, 1023));
    end else if (hi > lo + 1) begin
      s.soil_raw = 10'($urandom_range(lo + 1, hi - 1));
    end else begin
      s.soil_raw = 10'($urandom_range(0, 1023));
    end

    // soil percent: wet, dry or anywhere
    if (wet_mode == 1 && wet_set < 100) begin
      s.soil_percent = 7'($urandom_range(wet_set + 1, 100));
    end else if (wet_mode == 2) begin
      s.soil_percent = 7'($urandom_range(0, (wet_clr > 100) ? 100 : wet_clr));
    end else begin
      s.soil_percent = 7'($urandom_range(0, 100));
    end

    // noise beat
    if ($urandom_range(0, 9) == 0) begin
      s.now_ms = $urandom();
      s.temp_valid = 1'($urandom_range(0, 1));
      s.humi_valid = 1'($urandom_range(0, 1));
      s.temp_tenths = 12'(int'($urandom_range(0, 4000)) - 2000);
      s.soil_raw = 10'($urandom_range(0, 1023));
      s.soil_percent = 7'($urandom_range(0, 100));
    end
    return s;
  endfunction

  // Drive one sample beat and hold it until taken
  task automatic send_sample(input sample_t s, input logic known, input result_t res);
    tracking_i = s.tracking;
    now_ms_i = s.now_ms;
    temp_valid_i = s.temp_valid;
    humi_valid_i = s.humi_valid;
    temp_tenths_i = s.temp_tenths;
    soil_raw_i = s.soil_raw;
    soil_percent_i = s.soil_percent;
    pin_known = known;
    pin_res = res;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold off the sample channel until every result has left
  task automatic wait_drain();
    in_valid_i = 1'b0;
    while (supervisor_out_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [31:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Program every threshold, plus one write to an unused index
  task automatic program_limits(input logic [31:0] delay, input int raw_lo, input int raw_hi,
                                input int wet_set, input int wet_clr, input int floor_t);
    wait_drain();
    write_reg(CFG_FAULT_DELAY, delay);
    write_reg(CFG_SOIL_RAW_LOW, 32'(raw_lo));
    write_reg(CFG_SOIL_RAW_HIGH, 32'(raw_hi));
    write_reg(CFG_WET_SET, 32'(wet_set));
    write_reg(CFG_WET_CLEAR, 32'(wet_clr));
    write_reg(CFG_TEMP_FLOOR, 32'(floor_t));
    write_reg(($urandom_range(0, 1) == 0) ? IdxSpareA : IdxSpareB, $urandom());
  endtask

  // Send random samples in bursts with random gaps
  task automatic run_phase(input int n_items, input logic [31:0] start_ms, input bit hold_mid);
    int sent;
    int burst;
    cur_ms = start_ms;
    air_bad = 1'($urandom_range(0, 1));
    soil_bad = 1'($urandom_range(0, 1));
    wet_mode = $urandom_range(0, 2);
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < n_items; k++) begin
        send_sample(next_sample(), 1'b0, ResIdle);
        sent++;
        if (hold_mid && sent == n_items / 2) wait_drain();
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
    in_valid_i = 1'b0;
  endtask

  // Receiver: alternate stall and free runs, sometimes long free stretches
  initial begin
    int   run_left;
    logic stalling;
    out_stall_i = 1'b0;
    run_left = 0;
    stalling = 1'b0;
    forever begin
      @(negedge clk_i);
      if (run_left == 0) begin
        stalling = !stalling;
        if (stalling) run_left = $urandom_range(1, 5);
        else if ($urandom_range(0, 7) == 0) run_left = $urandom_range(30, 80);
        else run_left = $urandom_range(1, 6);
      end
      out_stall_i = stalling;
      run_left--;
    end
  end

  // Predict on accepted samples, check result beats, track register writes
  always @(posedge clk_i) begin
    sample_t seen;
    result_t want;
    if (out_fire) begin
      if (supervisor_out_q.size() == 0) begin
        $error("result beat with no sample waiting");
        fail_count++;
      end else begin
        want = supervisor_out_q.pop_front();
        check_field("safe_active", 2'(want.safe_active), 2'(safe_active_o));
        check_field("fault_code", want.fault_code, fault_code_o);
        check_field("pump_lock_cmd", want.pump_lock_cmd, pump_lock_cmd_o);
        check_field("mist_lock_cmd", want.mist_lock_cmd, mist_lock_cmd_o);
        check_field("fan_lock_clear", 2'(want.fan_lock_clear), 2'(fan_lock_clear_o));
        check_field("fan_cycle_cmd", want.fan_cycle_cmd, fan_cycle_cmd_o);
      end
    end
    if (in_fire) begin
      seen.tracking = tracking_i;
      seen.now_ms = now_ms_i;
      seen.temp_valid = temp_valid_i;
      seen.humi_valid = humi_valid_i;
      seen.temp_tenths = temp_tenths_i;
      seen.soil_raw = soil_raw_i;
      seen.soil_percent = soil_percent_i;
      want = supervise(seen);
      if (pin_known) want = pin_res;
      supervisor_out_q.push_back(want);
    end
    if (cfg_fire) begin
      case (cfg_index_i)
        CFG_FAULT_DELAY:   sup_cfg.fault_delay_ms = cfg_data_i;
        CFG_SOIL_RAW_LOW:  sup_cfg.soil_raw_low = cfg_data_i[9:0];
        CFG_SOIL_RAW_HIGH: sup_cfg.soil_raw_high = cfg_data_i[9:0];
        CFG_WET_SET:       sup_cfg.overwater_set_pct = cfg_data_i[6:0];
        CFG_WET_CLEAR:     sup_cfg.overwater_clear_pct = cfg_data_i[6:0];
        CFG_TEMP_FLOOR:    sup_cfg.temp_floor_tenths = cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk_i) begin
    if (in_fire || out_fire || cfg_fire) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("** sensor_fault_supervisor_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    int wet_set;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    tracking_i = 1'b0;
    now_ms_i = '0;
    temp_valid_i = 1'b0;
    humi_valid_i = 1'b0;
    temp_tenths_i = '0;
    soil_raw_i = '0;
    soil_percent_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    pin_known = 1'b0;
    pin_res = ResIdle;
    fail_count = 0;
    quiet_cycles = 0;
    cur_ms = '0;
    air_bad = 1'b0;
    soil_bad = 1'b0;
    wet_mode = 0;
    sup_cfg = '{FaultDelayRst, SoilRawLowRst, SoilRawHighRst, WetSetRst, WetClearRst,
                TempFloorRst};
    sup_safe = 1'b0;
    sup_code = CODE_NONE;
    air_wait = 1'b0;
    air_since = '0;
    soil_wait = 1'b0;
    soil_since = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows at reset thresholds
    for (int i = 0; i < NumDirRows; i++) begin
      send_sample(DirRows[i].smp, DirRows[i].pinned, DirRows[i].res);
    end
    in_valid_i = 1'b0;

    // typical thresholds with a short delay
    program_limits(32'd50, 5, 1020, 85, 80, -1000);
    run_phase(PhaseItems, 32'd1000, 1'b0);

    // widest soil window, no delay, coldest floor
    program_limits(32'd0, 0, 1023, 100, 0, -2000);
    run_phase(PhaseItems, $urandom(), 1'b0);

    // inverted soil window, endless delay, wet set below clear, hottest floor
    program_limits(32'hFFFF_FFFF, 1023, 0, 0, 100, 2000);
    run_phase(PhaseItems, $urandom(), 1'b0);

    // wet set at or below clear; pause midway until drained
    wet_set = $urandom_range(0, 50);
    program_limits($urandom_range(0, 300), $urandom_range(0, 100), $urandom_range(900, 1023),
                   wet_set, $urandom_range(wet_set, 100), -int'($urandom_range(0, 2000)));
    run_phase(PhaseItems, 32'hFFFF_F000, 1'b1);

    // mid thresholds across the time wrap
    program_limits(32'd200, 20, 1000, 60, 40, 0);
    run_phase(PhaseItems, 32'hFFFF_FF80, 1'b0);

    // anything in range
    program_limits($urandom_range(0, 500), $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 100), $urandom_range(0, 100),
                   int'($urandom_range(0, 4000)) - 2000);
    run_phase(PhaseItems, $urandom(), 1'b0);

    // drain and let any stray beat show up
    wait_drain();
    repeat (DrainCycles) @(negedge clk_i);
    if (supervisor_out_q.size() != 0) begin
      $error("%0d results never arrived", supervisor_out_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("** sensor_fault_supervisor_unit: PASSED **");
    end else begin
      $display("** sensor_fault_supervisor_unit: FAILED **");
    end
    $finish;
  end

endmodule
